// ----- src/dq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and index helpers for the bounded deque with search.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Ring buffer geometry
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Command codes carried in the kind field
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_SEARCH     = 3'd4,
    KIND_CLEAR      = 3'd5
  } dq_kind_e;

  // Incoming request
  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
  } dq_req_t;

  // Outgoing response
  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         item_count;
    logic                     is_empty;
    logic                     rejected;
  } dq_rsp_t;

  // Entry store access for one cycle
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } dq_ram_req_t;

  // Ring position of the entry at a given offset from the head (offset below CAPACITY)
  function automatic logic [IDX_W-1:0] dq_slot(logic [IDX_W-1:0] head,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Ring position one before the head
  function automatic logic [IDX_W-1:0] dq_prev(logic [IDX_W-1:0] head);
    logic [IDX_W-1:0] res;
    if (head == '0) begin
      res = IDX_W'(CAPACITY - 1);
    end else begin
      res = head - IDX_W'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- src/dq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dq_ram (
  input  wire logic                       clk_i,
  input  wire dq_pkg::dq_ram_req_t        ram_req_i,
  output logic [dq_pkg::DATA_W-1:0]       rd_data_o
);

  logic [dq_pkg::DATA_W-1:0] mem_q [dq_pkg::CAPACITY];
  logic [dq_pkg::DATA_W-1:0] rd_data_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (ram_req_i.we) begin
      mem_q[ram_req_i.waddr] <= ram_req_i.wdata;
    end
  end

  // Registered read: data for the address appears in the cycle after
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[ram_req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ----- src/dq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Command sequencer: head and count tracking, front/back caching, serial
// search over the entry store and the response register.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire dq_pkg::dq_req_t            in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output dq_pkg::dq_rsp_t                 out_rsp_o,
  output dq_pkg::dq_ram_req_t             ram_req_o,
  input  wire logic [dq_pkg::DATA_W-1:0]  rd_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } dq_state_e;

  localparam logic [dq_pkg::CNT_W-1:0] CNT_FULL = dq_pkg::CNT_W'(dq_pkg::CAPACITY);
  localparam logic [dq_pkg::CNT_W-1:0] CNT_ONE  = dq_pkg::CNT_W'(1);
  localparam logic [dq_pkg::CNT_W-1:0] CNT_TWO  = dq_pkg::CNT_W'(2);

  dq_state_e                 state_q, state_d;
  logic [dq_pkg::IDX_W-1:0]  head_q, head_d;
  logic [dq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [dq_pkg::CNT_W-1:0]  scan_q, scan_d;
  logic [dq_pkg::DATA_W-1:0] front_q, front_d;
  logic [dq_pkg::DATA_W-1:0] back_q, back_d;
  logic [dq_pkg::DATA_W-1:0] key_q, key_d;
  logic                      fetch_front_q, fetch_front_d;
  logic                      found_q, found_d;
  logic                      rej_q, rej_d;
  logic                      out_valid_q, out_valid_d;
  dq_pkg::dq_rsp_t           out_q, out_d;
  logic [dq_pkg::IDX_W-1:0]  new_head;
  logic                      is_empty;

  assign is_empty = (count_q == '0);
  assign new_head = dq_pkg::dq_prev(head_q);

  // Next-state logic for the sequencer
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    scan_d        = scan_q;
    front_d       = front_q;
    back_d        = back_q;
    key_d         = key_q;
    fetch_front_d = fetch_front_q;
    found_d       = found_q;
    rej_d         = rej_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = dq_pkg::dq_slot(head_q, count_q);
    ram_req_o.wdata = in_req_i.value;
    ram_req_o.raddr = dq_pkg::dq_slot(head_q, scan_q);

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d   = in_req_i.value;
          found_d = 1'b0;
          rej_d   = 1'b0;
          state_d = ST_DONE;
          case (in_req_i.kind)
            dq_pkg::KIND_PUSH_FRONT: begin
              if (count_q == CNT_FULL) begin
                rej_d = 1'b1;
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = new_head;
                head_d          = new_head;
                count_d         = count_q + CNT_ONE;
                front_d         = in_req_i.value;
                if (is_empty) begin
                  back_d = in_req_i.value;
                end
              end
            end
            dq_pkg::KIND_PUSH_BACK: begin
              if (count_q == CNT_FULL) begin
                rej_d = 1'b1;
              end else begin
                ram_req_o.we = 1'b1;
                count_d      = count_q + CNT_ONE;
                back_d       = in_req_i.value;
                if (is_empty) begin
                  front_d = in_req_i.value;
                end
              end
            end
            dq_pkg::KIND_POP_FRONT: begin
              if (is_empty) begin
                rej_d = 1'b1;
              end else begin
                head_d  = dq_pkg::dq_slot(head_q, CNT_ONE);
                count_d = count_q - CNT_ONE;
                if (count_q != CNT_ONE) begin
                  // fetch the new front entry
                  ram_req_o.raddr = dq_pkg::dq_slot(head_q, CNT_ONE);
                  fetch_front_d   = 1'b1;
                  state_d         = ST_FETCH;
                end
              end
            end
            dq_pkg::KIND_POP_BACK: begin
              if (is_empty) begin
                rej_d = 1'b1;
              end else begin
                count_d = count_q - CNT_ONE;
                if (count_q != CNT_ONE) begin
                  // fetch the new back entry
                  ram_req_o.raddr = dq_pkg::dq_slot(head_q, count_q - CNT_TWO);
                  fetch_front_d   = 1'b0;
                  state_d         = ST_FETCH;
                end
              end
            end
            dq_pkg::KIND_SEARCH: begin
              if (!is_empty) begin
                ram_req_o.raddr = head_q;
                scan_d          = CNT_ONE;
                state_d         = ST_SCAN;
              end
            end
            dq_pkg::KIND_CLEAR: begin
              count_d = '0;
              head_d  = '0;
            end
            default: begin
              // unused codes leave the queue alone
            end
          endcase
        end
      end

      ST_FETCH: begin
        if (fetch_front_q) begin
          front_d = rd_data_i;
        end else begin
          back_d = rd_data_i;
        end
        state_d = ST_DONE;
      end

      // Compare the entry read last cycle, issue the next read
      ST_SCAN: begin
        if (rd_data_i == key_q) begin
          found_d = 1'b1;
          state_d = ST_DONE;
        end else if (scan_q == count_q) begin
          state_d = ST_DONE;
        end else begin
          scan_d = scan_q + CNT_ONE;
        end
      end

      // Load the response register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.found       = found_q;
          out_d.front_value = is_empty ? '0 : front_q;
          out_d.back_value  = is_empty ? '0 : back_q;
          out_d.item_count  = count_q;
          out_d.is_empty    = is_empty;
          out_d.rejected    = rej_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    scan_q        <= scan_d;
    front_q       <= front_d;
    back_q        <= back_d;
    key_q         <= key_d;
    fetch_front_q <= fetch_front_d;
    found_q       <= found_d;
    rej_q         <= rej_d;
    out_q         <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

// ----- src/bounded_deque_with_search.sv -----
`default_nettype none
// Flow: push, clear and refused requests pass from acceptance through ST_DONE into the
// response register; pops that fetch a new end entry pass through ST_FETCH first; a search
// on a non-empty queue walks the held entries in ST_SCAN. A new request is taken only in
// ST_IDLE, so a search holds requests off while the single read port walks entry by entry.
// Reset clears head, count and handshake state at once; entries are not cleared.
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed values in a ring-buffer memory,
// with push/pop at either end, value search and clear.
// ----------------------------------------------------------------------------
module bounded_deque_with_search (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire dq_pkg::dq_req_t  in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output dq_pkg::dq_rsp_t       out_rsp_o
);

  dq_pkg::dq_ram_req_t       ram_req;
  logic [dq_pkg::DATA_W-1:0] rd_data;

  // Sequencer
  dq_ctrl u_dq_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .ram_req_o   (ram_req),
    .rd_data_i   (rd_data)
  );

  // Entry store
  dq_ram u_dq_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rd_data_o (rd_data)
  );

endmodule
`default_nettype wire

// ----- src/dq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque responses, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire dq_pkg::dq_rsp_t  out_rsp_o
);

  // Hold a stalled response
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped or changed while stalled");

  // Empty flag agrees with the count
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.is_empty == (out_rsp_o.item_count == '0)))
    else $error("empty flag disagrees with count");

  // Zero end values on an empty queue
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.is_empty |->
      (out_rsp_o.front_value == '0) && (out_rsp_o.back_value == '0))
    else $error("non-zero end value on empty queue");

  // Count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.item_count <= dq_pkg::CNT_W'(dq_pkg::CAPACITY)))
    else $error("count beyond capacity");

  // Take one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in progress");

endmodule

bind bounded_deque_with_search dq_checker u_dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
`default_nettype wire
